// ===== rtl/core/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants for the record deframer
// Phase codes, result word layout, signature table and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int SIG_LEN_DEF = 15;
  localparam int SIG_IDX_W   = 4;

  localparam logic [15:0] CRC_POLY = 16'h8408;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_REC_END   = 2'd1,
    KIND_DGRAM_END = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_SIG_BAD   = 2'd0,
    ST_END_CMD   = 2'd1,
    ST_CLEAN     = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic [9:0] {
    PH_SIG    = 10'b00_0000_0001,
    PH_CMD_LO = 10'b00_0000_0010,
    PH_CMD_HI = 10'b00_0000_0100,
    PH_LEN_LO = 10'b00_0000_1000,
    PH_LEN_HI = 10'b00_0001_0000,
    PH_DATA   = 10'b00_0010_0000,
    PH_CRC_LO = 10'b00_0100_0000,
    PH_CRC_HI = 10'b00_1000_0000,
    PH_ENDCMD = 10'b01_0000_0000,
    PH_BADSIG = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [15:0] command;
    logic [15:0] length;
    logic        crc_ok;
    status_t     status;
    logic        last_of_run;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [SIG_IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h42;  // B
      4'd1:    b = 8'h65;  // e
      4'd2:    b = 8'h43;  // C
      4'd3:    b = 8'h6B;  // k
      4'd4:    b = 8'h4D;  // M
      4'd5:    b = 8'h61;  // a
      4'd6:    b = 8'h4E;  // N
      4'd7:    b = 8'h6E;  // n
      4'd8:    b = 8'h5F;  // _
      4'd9:    b = 8'h52;  // R
      4'd10:   b = 8'h65;  // e
      4'd11:   b = 8'h4D;  // M
      4'd12:   b = 8'h6F;  // o
      4'd13:   b = 8'h54;  // T
      4'd14:   b = 8'h65;  // e
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // reflected CRC-16, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/rdc_in_if.sv =====
// ----------------------------------------------------------------------------
// rdc_in_if: datagram byte channel
// One word per payload byte, with a flag on the last byte of the datagram.
// ----------------------------------------------------------------------------
interface rdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       final_byte;

  modport source (output valid, output payload_byte, output final_byte, input ready);
  modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

// ===== rtl/core/rdc_out_if.sv =====
// ----------------------------------------------------------------------------
// rdc_out_if: result channel
// Data bytes, record ends and datagram ends, one word each.
// ----------------------------------------------------------------------------
interface rdc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] command;
  logic [15:0] length;
  logic        crc_ok;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, output kind, output out_byte, output command,
                  output length, output crc_ok, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input command,
                  input length, input crc_ok, input status, input last_of_run,
                  output ready);
endinterface

// ===== rtl/core/rdc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rdc_cfg_if: configuration write channel
// Carries the end command register value.
// ----------------------------------------------------------------------------
interface rdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] end_command;

  modport source (output valid, output end_command, input ready);
  modport sink   (input valid, input end_command, output ready);
endinterface

// ===== rtl/core/record_deframer_crc16_check.sv =====
// ----------------------------------------------------------------------------
// record_deframer_crc16_check: signature match, record parse, CRC-16 check
// Parses one datagram byte per word; emits data bytes, record ends with a
// CRC verdict, and a datagram end with a status.
// ----------------------------------------------------------------------------
//  channel  dir  words
//  in_ch    in   payload_byte, final_byte
//  out_ch   out  kind, out_byte, command, length, crc_ok, status, last_of_run
//  cfg_ch   in   end_command (always ready)
//
//  One input word per cycle when ready; parser state and CRC update per word.
//  Each word yields 0..2 result words into a 4-entry result queue.
//  in_ch.ready is high while the queue holds 2 words or fewer, leaving room
//  for both results that one input word can cause.
//  Synchronous active-low reset; parser returns to signature match after
//  each final byte.
// ----------------------------------------------------------------------------
module record_deframer_crc16_check #(
  parameter int SIG_LEN = rdc_pkg::SIG_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rdc_in_if.sink        in_ch,
  rdc_out_if.source     out_ch,
  rdc_cfg_if.sink       cfg_ch
);

  localparam logic [rdc_pkg::SIG_IDX_W-1:0] SIG_LAST = rdc_pkg::SIG_IDX_W'(SIG_LEN - 1);

  logic [15:0]                     end_cmd_r;
  rdc_pkg::phase_t                 phase_r, phase_nxt, phase_upd;
  logic [rdc_pkg::SIG_IDX_W-1:0]   sig_idx_r, sig_idx_nxt;
  logic                            sig_bad_r, sig_bad_nxt;
  logic [15:0]                     cmd_r, cmd_nxt;
  logic [15:0]                     len_r, len_nxt;
  logic [15:0]                     cnt_data_r, cnt_data_nxt;
  logic [15:0]                     crc_r, crc_nxt;
  logic [7:0]                      crc_lo_r, crc_lo_nxt;

  rdc_pkg::result_t                q_r [4];
  logic [1:0]                      head_r, tail_r;
  logic [2:0]                      qcnt_r, qcnt_nxt;

  logic                            acc, pop, fin;
  logic [7:0]                      b;
  logic                            prim_v;
  rdc_pkg::result_t                prim_res, fin_res, first_res;
  logic [1:0]                      push_n;
  logic [15:0]                     cmd_full, len_full, cnt_inc;

  assign acc = in_ch.valid && in_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;
  assign b   = in_ch.payload_byte;
  assign fin = in_ch.final_byte;

  assign in_ch.ready  = (qcnt_r <= 3'd2);
  assign cfg_ch.ready = 1'b1;

  assign cmd_full = {b, cmd_r[7:0]};
  assign len_full = {b, len_r[7:0]};
  assign cnt_inc  = (cnt_data_r == 16'hFFFF) ? cnt_data_r : cnt_data_r + 16'd1;

  always_comb begin
    phase_upd    = phase_r;
    sig_idx_nxt  = sig_idx_r;
    sig_bad_nxt  = sig_bad_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    cnt_data_nxt = cnt_data_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    prim_v       = 1'b0;
    prim_res     = '0;
    unique case (phase_r)
      rdc_pkg::PH_SIG: begin
        if (b != rdc_pkg::sig_byte(sig_idx_r)) begin
          sig_bad_nxt = 1'b1;
        end
        sig_idx_nxt = sig_idx_r + rdc_pkg::SIG_IDX_W'(1);
        if (sig_idx_r == SIG_LAST) begin
          phase_upd = (sig_bad_nxt) ? rdc_pkg::PH_BADSIG : rdc_pkg::PH_CMD_LO;
        end
      end
      rdc_pkg::PH_CMD_LO: begin
        crc_nxt   = rdc_pkg::crc_step(16'h0000, b);
        cmd_nxt   = {8'h00, b};
        phase_upd = rdc_pkg::PH_CMD_HI;
      end
      rdc_pkg::PH_CMD_HI: begin
        crc_nxt   = rdc_pkg::crc_step(crc_r, b);
        cmd_nxt   = cmd_full;
        phase_upd = (cmd_full == end_cmd_r) ? rdc_pkg::PH_ENDCMD : rdc_pkg::PH_LEN_LO;
      end
      rdc_pkg::PH_LEN_LO: begin
        crc_nxt   = rdc_pkg::crc_step(crc_r, b);
        len_nxt   = {8'h00, b};
        phase_upd = rdc_pkg::PH_LEN_HI;
      end
      rdc_pkg::PH_LEN_HI: begin
        crc_nxt      = rdc_pkg::crc_step(crc_r, b);
        len_nxt      = len_full;
        cnt_data_nxt = '0;
        phase_upd    = (len_full == 16'h0000) ? rdc_pkg::PH_CRC_LO : rdc_pkg::PH_DATA;
      end
      rdc_pkg::PH_DATA: begin
        crc_nxt           = rdc_pkg::crc_step(crc_r, b);
        prim_v            = 1'b1;
        prim_res.kind     = rdc_pkg::KIND_DATA;
        prim_res.out_byte = b;
        cnt_data_nxt      = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_upd = rdc_pkg::PH_CRC_LO;
        end
      end
      rdc_pkg::PH_CRC_LO: begin
        crc_lo_nxt = b;
        phase_upd  = rdc_pkg::PH_CRC_HI;
      end
      rdc_pkg::PH_CRC_HI: begin
        prim_v           = 1'b1;
        prim_res.kind    = rdc_pkg::KIND_REC_END;
        prim_res.command = cmd_r;
        prim_res.length  = len_r;
        prim_res.crc_ok  = ({b, crc_lo_r} == crc_r);
        phase_upd        = rdc_pkg::PH_CMD_LO;
      end
      rdc_pkg::PH_ENDCMD: begin
      end
      rdc_pkg::PH_BADSIG: begin
      end
      default: begin
      end
    endcase

    fin_res      = '0;
    fin_res.kind = rdc_pkg::KIND_DGRAM_END;
    priority if (phase_upd == rdc_pkg::PH_BADSIG || phase_upd == rdc_pkg::PH_SIG) begin
      fin_res.status = rdc_pkg::ST_SIG_BAD;
    end else if (phase_upd == rdc_pkg::PH_ENDCMD) begin
      fin_res.status = rdc_pkg::ST_END_CMD;
    end else if (phase_upd == rdc_pkg::PH_CMD_LO) begin
      fin_res.status = rdc_pkg::ST_CLEAN;
    end else begin
      fin_res.status = rdc_pkg::ST_TRUNCATED;
    end
    fin_res.last_of_run  = 1'b1;
    prim_res.last_of_run = !fin;

    first_res = prim_v ? prim_res : fin_res;
    push_n    = acc ? ({1'b0, prim_v} + {1'b0, fin}) : 2'd0;

    phase_nxt = phase_upd;
    if (fin) begin
      phase_nxt   = rdc_pkg::PH_SIG;
      sig_idx_nxt = '0;
      sig_bad_nxt = 1'b0;
    end

    qcnt_nxt = qcnt_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_cmd_r <= '0;
      phase_r   <= rdc_pkg::PH_SIG;
      sig_idx_r <= '0;
      sig_bad_r <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      qcnt_r    <= '0;
    end else begin
      if (cfg_ch.valid) begin
        end_cmd_r <= cfg_ch.end_command;
      end
      if (acc) begin
        phase_r   <= phase_nxt;
        sig_idx_r <= sig_idx_nxt;
        sig_bad_r <= sig_bad_nxt;
      end
      if (pop) begin
        head_r <= head_r + 2'd1;
      end
      tail_r <= tail_r + push_n;
      qcnt_r <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      cnt_data_r <= cnt_data_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
    if (push_n != 2'd0) begin
      q_r[tail_r] <= first_res;
    end
    if (push_n == 2'd2) begin
      q_r[tail_r + 2'd1] <= fin_res;
    end
  end

  assign out_ch.valid       = (qcnt_r != 3'd0);
  assign out_ch.kind        = q_r[head_r].kind;
  assign out_ch.out_byte    = q_r[head_r].out_byte;
  assign out_ch.command     = q_r[head_r].command;
  assign out_ch.length      = q_r[head_r].length;
  assign out_ch.crc_ok      = q_r[head_r].crc_ok;
  assign out_ch.status      = q_r[head_r].status;
  assign out_ch.last_of_run = q_r[head_r].last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 3'd4)
    else $error("result queue overflow");

  a_fin_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && fin |=> phase_r == rdc_pkg::PH_SIG && sig_idx_r == '0 && !sig_bad_r)
    else $error("parser not restarted after final byte");

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rdc_pkg::PH_DATA |-> cnt_data_r < len_r)
    else $error("data count past record length");

  a_dgram_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == rdc_pkg::KIND_DGRAM_END |-> out_ch.last_of_run)
    else $error("datagram end not last of run");

endmodule

// ===== tb/sv/rdc_checker.sv =====
// ----------------------------------------------------------------------------
// rdc_checker: scoreboard for the record deframer
// Follows every accepted datagram byte with its own parser state and
// CRC-16/KERMIT accumulator, queues the words the block should emit and
// compares each accepted result word against the oldest one queued.
// ----------------------------------------------------------------------------
module rdc_checker #(
  parameter int SIG_LEN = rdc_pkg::SIG_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rdc_in_if    in_mon,
  rdc_out_if   out_mon,
  rdc_cfg_if   cfg_mon,
  output int   errors,
  output int   outstanding
);

  localparam logic [8*15-1:0] SIGNATURE_TEXT = "BeCkMaNn_ReMoTe";

  logic [15:0]      end_cmd;
  rdc_pkg::phase_t  parse_phase;
  logic [3:0]       sig_idx;
  logic             sig_bad;
  logic [15:0]      rec_cmd;
  logic [15:0]      rec_len;
  logic [15:0]      data_cnt;
  logic [15:0]      crc_acc;
  logic [7:0]       crc_lo;

  rdc_pkg::result_t expected_words[$];
  int               mismatches = 0;

  function automatic logic [15:0] kermit_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ rdc_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic string word_text(input rdc_pkg::result_t w);
    return $sformatf("kind=%0d byte=%02h cmd=%04h len=%04h crc_ok=%b status=%0d last=%b",
                     w.kind, w.out_byte, w.command, w.length, w.crc_ok, w.status,
                     w.last_of_run);
  endfunction

  task automatic clear_datagram();
    parse_phase = rdc_pkg::PH_SIG;
    sig_idx     = '0;
    sig_bad     = 1'b0;
    rec_cmd     = '0;
    rec_len     = '0;
    data_cnt    = '0;
    crc_acc     = '0;
    crc_lo      = '0;
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // parse one byte, queue the words it causes
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    rdc_pkg::result_t batch[$];
    rdc_pkg::result_t w;
    rdc_pkg::status_t st;
    w = '0;
    case (parse_phase)
      rdc_pkg::PH_SIG: begin
        if (sig_idx < SIG_LEN && b != SIGNATURE_TEXT[8*(14-sig_idx) +: 8]) sig_bad = 1'b1;
        sig_idx = sig_idx + 4'd1;
        if (sig_idx >= SIG_LEN) parse_phase = sig_bad ? rdc_pkg::PH_BADSIG : rdc_pkg::PH_CMD_LO;
      end
      rdc_pkg::PH_CMD_LO: begin
        crc_acc     = kermit_update(16'h0000, b);
        rec_cmd     = {8'h00, b};
        parse_phase = rdc_pkg::PH_CMD_HI;
      end
      rdc_pkg::PH_CMD_HI: begin
        crc_acc     = kermit_update(crc_acc, b);
        rec_cmd     = {b, rec_cmd[7:0]};
        parse_phase = (rec_cmd == end_cmd) ? rdc_pkg::PH_ENDCMD : rdc_pkg::PH_LEN_LO;
      end
      rdc_pkg::PH_LEN_LO: begin
        crc_acc     = kermit_update(crc_acc, b);
        rec_len     = {8'h00, b};
        parse_phase = rdc_pkg::PH_LEN_HI;
      end
      rdc_pkg::PH_LEN_HI: begin
        crc_acc     = kermit_update(crc_acc, b);
        rec_len     = {b, rec_len[7:0]};
        data_cnt    = '0;
        parse_phase = (rec_len == 16'h0000) ? rdc_pkg::PH_CRC_LO : rdc_pkg::PH_DATA;
      end
      rdc_pkg::PH_DATA: begin
        crc_acc    = kermit_update(crc_acc, b);
        w.kind     = rdc_pkg::KIND_DATA;
        w.out_byte = b;
        batch.push_back(w);
        if (data_cnt != 16'hFFFF) data_cnt = data_cnt + 16'd1;
        if (data_cnt >= rec_len) parse_phase = rdc_pkg::PH_CRC_LO;
      end
      rdc_pkg::PH_CRC_LO: begin
        crc_lo      = b;
        parse_phase = rdc_pkg::PH_CRC_HI;
      end
      rdc_pkg::PH_CRC_HI: begin
        w.kind      = rdc_pkg::KIND_REC_END;
        w.command   = rec_cmd;
        w.length    = rec_len;
        w.crc_ok    = ({b, crc_lo} == crc_acc);
        batch.push_back(w);
        parse_phase = rdc_pkg::PH_CMD_LO;
      end
      default: ;
    endcase
    if (fin) begin
      case (parse_phase)
        rdc_pkg::PH_SIG, rdc_pkg::PH_BADSIG: st = rdc_pkg::ST_SIG_BAD;
        rdc_pkg::PH_ENDCMD:                  st = rdc_pkg::ST_END_CMD;
        rdc_pkg::PH_CMD_LO:                  st = rdc_pkg::ST_CLEAN;
        default:                             st = rdc_pkg::ST_TRUNCATED;
      endcase
      w        = '0;
      w.kind   = rdc_pkg::KIND_DGRAM_END;
      w.status = st;
      batch.push_back(w);
      clear_datagram();
    end
    if (batch.size() > 0) begin
      w = batch[batch.size()-1];
      w.last_of_run = 1'b1;
      batch[batch.size()-1] = w;
    end
    foreach (batch[i]) expected_words.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    rdc_pkg::result_t got;
    rdc_pkg::result_t want;
    if (!rst_n) begin
      end_cmd = '0;
      clear_datagram();
      expected_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.payload_byte, in_mon.final_byte);
      if (cfg_mon.valid && cfg_mon.ready) end_cmd = cfg_mon.end_command;
      if (out_mon.valid && out_mon.ready) begin
        got.kind        = rdc_pkg::kind_t'(out_mon.kind);
        got.out_byte    = out_mon.out_byte;
        got.command     = out_mon.command;
        got.length      = out_mon.length;
        got.crc_ok      = out_mon.crc_ok;
        got.status      = rdc_pkg::status_t'(out_mon.status);
        got.last_of_run = out_mon.last_of_run;
        if (expected_words.size() == 0) begin
          note_failure({"unexpected word: ", word_text(got)});
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
              got.command !== want.command || got.length !== want.length ||
              got.crc_ok !== want.crc_ok || got.status !== want.status ||
              got.last_of_run !== want.last_of_run) begin
            note_failure({"expected ", word_text(want), " got ", word_text(got)});
          end
        end
      end
    end
    errors      <= mismatches;
    outstanding <= expected_words.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for record_deframer_crc16_check
// Sends directed and random datagrams (good and corrupted signatures,
// records with good and bad CRCs, end commands, truncations) with random
// gaps and output stalls under several end command settings; the checker
// compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT     = 2_000_000;
  localparam int LONG_HOLD = 200;
  localparam logic [8*15-1:0] SIGNATURE_TEXT = "BeCkMaNn_ReMoTe";

  logic        clk;
  logic        rst_n;
  logic        hold_req;
  int          errors;
  int          outstanding;
  int          cycle_count;
  int          send_mode;
  int          recv_mode;
  int          sent_words = 0;
  logic [15:0] end_cmd_setting;
  logic [7:0]  dgram[$];

  rdc_in_if  in_ch ();
  rdc_out_if out_ch ();
  rdc_cfg_if cfg_ch ();

  record_deframer_crc16_check i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rdc_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] kermit_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int   stall_left;
    logic held;
    stall_left = 0;
    held       = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (recv_mode != 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    gap = (send_mode != 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= b;
    in_ch.final_byte   <= fin;
    do @(posedge clk); while (!in_ch.ready);
    sent_words++;
  endtask

  task automatic send_datagram();
    foreach (dgram[i]) send_word(dgram[i], i == dgram.size() - 1);
    dgram.delete();
  endtask

  // drain every expected word, let the parser settle, then write the register
  task automatic set_end_command(input logic [15:0] v);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.end_command <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid    <= 1'b0;
    end_cmd_setting = v;
  endtask

  task automatic add_signature(input int n, input int bad_at);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = SIGNATURE_TEXT[8*(14-i) +: 8];
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      dgram.push_back(b);
    end
  endtask

  task automatic add_random_bytes(input int n);
    repeat (n) dgram.push_back(8'($urandom));
  endtask

  task automatic add_end_command();
    dgram.push_back(end_cmd_setting[7:0]);
    dgram.push_back(end_cmd_setting[15:8]);
  endtask

  // fill < 0 gives random data
  task automatic add_record(input logic [15:0] cmd, input logic [15:0] len, input logic bad_crc,
                            input int fill);
    logic [15:0] c;
    logic [7:0]  b;
    logic [7:0]  hdr[4];
    c   = 16'h0000;
    hdr = '{cmd[7:0], cmd[15:8], len[7:0], len[15:8]};
    foreach (hdr[i]) begin
      dgram.push_back(hdr[i]);
      c = kermit_update(c, hdr[i]);
    end
    for (int i = 0; i < int'(len); i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      dgram.push_back(b);
      c = kermit_update(c, b);
    end
    if (bad_crc) c = c ^ 16'($urandom_range(1, 16'hFFFF));
    dgram.push_back(c[7:0]);
    dgram.push_back(c[15:8]);
  endtask

  task automatic cut_to(input int n);
    while (dgram.size() > n) void'(dgram.pop_back());
  endtask

  function automatic logic [15:0] pick_command();
    logic [15:0] c;
    int r;
    r = $urandom_range(0, 9);
    c = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
    if (c == end_cmd_setting) c = c ^ 16'h0001;
    return c;
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 8));
    if (r < 95) return 16'($urandom_range(9, 40));
    return 16'($urandom_range(41, 300));
  endfunction

  task automatic build_random_datagram();
    int r;
    int start;
    int n;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 14);
      add_signature(n, ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1);
    end else if (r < 16) begin
      add_signature(rdc_pkg::SIG_LEN_DEF, $urandom_range(0, rdc_pkg::SIG_LEN_DEF - 1));
      add_random_bytes($urandom_range(0, 10));
    end else if (r < 20) begin
      add_random_bytes($urandom_range(1, 30));
    end else begin
      add_signature(rdc_pkg::SIG_LEN_DEF, -1);
      repeat ($urandom_range(0, 4))
        add_record(pick_command(), pick_length(), $urandom_range(0, 9) == 0, -1);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        add_end_command();
        add_random_bytes($urandom_range(0, 6));
      end else if (r < 50) begin
        start = dgram.size();
        add_record(pick_command(), pick_length(), 1'b0, -1);
        cut_to(start + $urandom_range(1, dgram.size() - start - 1));
      end
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = sent_words + n;
    while (sent_words < target) begin
      build_random_datagram();
      send_datagram();
    end
  endtask

  initial begin
    int start;
    in_ch.valid        <= 1'b0;
    in_ch.payload_byte <= 8'h00;
    in_ch.final_byte   <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.end_command <= 16'h0000;
    hold_req           <= 1'b0;
    rst_n              <= 1'b0;
    send_mode       = 1;
    recv_mode       = 1;
    end_cmd_setting = 16'h0000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_end_command(16'hFFFF);
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    send_datagram();
    add_signature(1, -1);
    send_datagram();
    add_signature(14, -1);
    send_datagram();
    add_signature(rdc_pkg::SIG_LEN_DEF, 0);
    add_random_bytes(4);
    send_datagram();
    add_signature(rdc_pkg::SIG_LEN_DEF, rdc_pkg::SIG_LEN_DEF - 1);
    send_datagram();
    // zero-length record, then end command with trailing junk
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    add_record(16'h0000, 16'h0000, 1'b0, -1);
    add_end_command();
    add_random_bytes(3);
    send_datagram();
    // data extremes and a bad CRC; final on CRC high byte
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    add_record(16'h8001, 16'd2, 1'b0, 8'h00);
    add_record(16'hFFFE, 16'd1, 1'b1, 8'hFF);
    send_datagram();
    // truncated after command, inside data, after CRC low byte
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    start = dgram.size();
    add_record(16'h1234, 16'd4, 1'b0, -1);
    cut_to(start + 2);
    send_datagram();
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    start = dgram.size();
    add_record(16'h00FF, 16'd4, 1'b0, -1);
    cut_to(start + 6);
    send_datagram();
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    start = dgram.size();
    add_record(16'hFF00, 16'd3, 1'b0, -1);
    cut_to(start + 8);
    send_datagram();

    set_end_command(16'h0000);
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    add_end_command();
    send_datagram();
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    add_record(16'hFFFF, 16'd3, 1'b0, -1);
    add_end_command();
    add_random_bytes(2);
    send_datagram();

    // widest length field, datagram ends inside the data
    send_mode = 0;
    recv_mode = 0;
    add_signature(rdc_pkg::SIG_LEN_DEF, -1);
    dgram.push_back(8'h5A);
    dgram.push_back(8'h5A);
    dgram.push_back(8'hFF);
    dgram.push_back(8'hFF);
    add_random_bytes(20);
    send_datagram();

    send_mode = 1;
    recv_mode = 1;
    run_random(240);

    set_end_command(16'hFFFF);
    send_mode = 0;
    recv_mode = 0;
    hold_req <= 1'b1;
    run_random(240);

    set_end_command(16'($urandom));
    send_mode = 1;
    recv_mode = 0;
    run_random(240);

    set_end_command(16'($urandom));
    send_mode = 0;
    recv_mode = 1;
    run_random(240);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
